/* rtl/core/twt_pkg.sv */
// Shared types and constants for the time-window tour block.
package twt_pkg;

    // Stored path and finish times never exceed the saturation value, so 30 bits hold them.
    localparam int DATA_W = 30;
    localparam logic [DATA_W-1:0] INF = 30'h3f3f3f3f;

    // Width of the result field.
    localparam int OUT_W = 5;

    // Default sizes handed to the top level.
    localparam int DEF_MAX_NODES  = 64;
    localparam int DEF_MAX_STORES = 16;
    localparam int DEF_TIME_BITS  = 16;

    // Command codes.
    typedef enum logic [1:0] {
        OP_WINDOW = 2'd0,
        OP_ROAD   = 2'd1,
        OP_RUN    = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_NODE_COUNT  = 1'b0,
        CFG_STORE_COUNT = 1'b1
    } cfg_t;

endpackage

/* rtl/core/twt_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module twt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read; a read of the address being written returns the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/twt_alu.sv */
// Shared saturating adder with a less-than compare against a third operand.
module twt_alu (
    input  logic [twt_pkg::DATA_W-1:0] a,
    input  logic [twt_pkg::DATA_W-1:0] b,
    input  logic [twt_pkg::DATA_W-1:0] c,
    output logic [twt_pkg::DATA_W-1:0] sum,
    output logic                       less
);

    logic [twt_pkg::DATA_W:0] raw;

    // The sum clamps at the saturation value; the compare tells whether it improves c.
    always_comb
    begin
        raw = {1'b0, a} + {1'b0, b};
        if (raw >= {1'b0, twt_pkg::INF})
        begin
            sum = twt_pkg::INF;
        end
        else
        begin
            sum = raw[twt_pkg::DATA_W-1:0];
        end
        less = (sum < c);
    end

endmodule

/* rtl/core/time_window_tour_max_stops.sv */
// Top level of the time-window tour block: sequencer, tables and RAMs.
//
// Commands enter on start while busy is low, with opcode and its fields.
// A window load (opcode 0) leaves busy low. A road load (opcode 1) writes
// one direction in the accept cycle and the other in the next cycle, so
// busy is high during the second write. A run (opcode 2) keeps busy high
// until done pulses for one cycle with max_stores; nothing else answers.
// Run steps share one saturating adder and the single read port
// of the closed distance RAM or the finish-time RAM.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// is always ready; writes are meant for times when the block is idle.
// After reset the road table is swept to its reset contents, one entry per
// cycle over all its entries (4096 at the default size), with busy high meanwhile.
// The done pulse is shown for exactly one cycle and cannot be held off; max_stores holds until the next run ends.
module time_window_tour_max_stops #(
    parameter int MAX_NODES  = twt_pkg::DEF_MAX_NODES,
    parameter int MAX_STORES = twt_pkg::DEF_MAX_STORES,
    parameter int TIME_BITS  = twt_pkg::DEF_TIME_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic [3:0]                store_index,
    input  logic [15:0]               open_time,
    input  logic [15:0]               close_time,
    input  logic [15:0]               service_time,
    input  logic [5:0]                road_from,
    input  logic [5:0]                road_to,
    input  logic [15:0]               road_length,
    output logic                      done,
    output logic [twt_pkg::OUT_W-1:0] max_stores,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [6:0]                cfg_data
);

    localparam int DW    = twt_pkg::DATA_W;
    localparam int NB    = $clog2(MAX_NODES);
    localparam int NCW   = $clog2(MAX_NODES + 1);
    localparam int SB    = (MAX_STORES > 1) ? $clog2(MAX_STORES) : 1;
    localparam int SCW   = $clog2(MAX_STORES + 1);
    localparam int MS    = MAX_STORES;
    localparam int DAW   = 2 * NB;
    localparam int EAW   = MS + SB;
    localparam int TKEEP = (TIME_BITS < 16) ? TIME_BITS : 16;
    localparam logic [15:0] TMASK = 16'((17'd1 << TKEEP) - 17'd1);

    typedef enum logic [4:0] {
        S_DCLR, S_IDLE, S_ROAD2, S_COPY, S_CPT,
        S_IK, S_IKW, S_KJ, S_IJ, S_FWU,
        S_EFCLR, S_INIR, S_INIW,
        S_RJ, S_RJW, S_RK, S_RKE, S_RKU,
        S_VJ, S_VJW, S_VN, S_VNU, S_VADV,
        S_SR, S_SC
    } state_t;

    state_t state_reg;

    logic [NCW-1:0] node_count_reg;
    logic [SCW-1:0] store_count_reg;
    logic [15:0] win_open_reg    [MAX_STORES];
    logic [15:0] win_close_reg   [MAX_STORES];
    logic [15:0] win_service_reg [MAX_STORES];

    logic [DAW-1:0] clr_reg;
    logic [DAW-1:0] cp_reg;
    logic [DAW-1:0] cp_wa_reg;
    logic           cp_wv_reg;
    logic [NB-1:0]  i_reg, j_reg, k_reg;
    logic [SB-1:0]  sj_reg, sk_reg;
    logic [MS-1:0]  set_reg;
    logic [DW-1:0]  ik_reg, kj_reg, efj_reg, cdjk_reg, done_reg;
    logic [NB-1:0]  road_a_reg, road_b_reg;
    logic [DW-1:0]  road_len_reg;
    logic [twt_pkg::OUT_W-1:0] best_reg;
    logic                      done_pulse_reg;
    logic [twt_pkg::OUT_W-1:0] max_stores_reg;

    logic accept;
    logic road_ok;
    logic [NB-1:0] nlast;
    logic [SB-1:0] mlast;
    logic [MS-1:0] full_mask;
    logic [MS-1:0] next_set;
    logic [DW-1:0] open_ext, close_ext, service_ext, start_t;

    logic           dist_we;
    logic [DAW-1:0] dist_waddr, dist_raddr;
    logic [DW-1:0]  dist_wdata, dist_rdata;
    logic           cd_we;
    logic [DAW-1:0] cd_waddr, cd_raddr;
    logic [DW-1:0]  cd_wdata, cd_rdata;
    logic           ef_we;
    logic [EAW-1:0] ef_waddr, ef_raddr;
    logic [DW-1:0]  ef_wdata, ef_rdata;
    logic [DW-1:0]  alu_a, alu_b, alu_c, alu_sum;
    logic           alu_less;
    logic [twt_pkg::OUT_W-1:0] pop;
    logic [twt_pkg::OUT_W-1:0] best_new;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign cfg_ready  = 1'b1;
    assign done       = done_pulse_reg;
    assign max_stores = max_stores_reg;

    // Loop bounds and per-store window values.
    always_comb
    begin
        road_ok     = (int'(road_from) < MAX_NODES) && (int'(road_to) < MAX_NODES);
        nlast       = NB'(node_count_reg - NCW'(1));
        mlast       = SB'(store_count_reg - SCW'(1));
        full_mask   = ~({MS{1'b1}} << store_count_reg);
        next_set    = set_reg | (MS'(1) << sj_reg);
        open_ext    = DW'(win_open_reg[sj_reg]);
        close_ext   = DW'(win_close_reg[sj_reg]);
        service_ext = DW'(win_service_reg[sj_reg]);
        start_t     = (ef_rdata > open_ext) ? ef_rdata : open_ext;
        pop         = twt_pkg::OUT_W'($countones(set_reg));
        best_new    = best_reg;
        if ((ef_rdata < twt_pkg::INF) && (pop > best_reg))
        begin
            best_new = pop;
        end
    end

    // Road table ports: reset sweep, road writes, and the copy read.
    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = clr_reg;
        dist_wdata = (clr_reg[DAW-1:NB] == clr_reg[NB-1:0]) ? '0 : twt_pkg::INF;
        dist_raddr = cp_reg;
        if (state_reg == S_DCLR)
        begin
            dist_we = 1'b1;
        end
        else if (accept && (opcode == twt_pkg::OP_ROAD) && road_ok)
        begin
            dist_we    = 1'b1;
            dist_waddr = {NB'(road_from), NB'(road_to)};
            dist_wdata = DW'(road_length & TMASK);
        end
        else if (state_reg == S_ROAD2)
        begin
            dist_we    = 1'b1;
            dist_waddr = {road_b_reg, road_a_reg};
            dist_wdata = road_len_reg;
        end
    end

    // Closed distance RAM ports.
    always_comb
    begin
        cd_we    = 1'b0;
        cd_waddr = cp_wa_reg;
        cd_wdata = dist_rdata;
        cd_raddr = '0;
        case (state_reg)
            S_COPY, S_CPT:
            begin
                cd_we = cp_wv_reg;
            end
            S_FWU:
            begin
                cd_we    = alu_less;
                cd_waddr = {i_reg, j_reg};
                cd_wdata = alu_sum;
            end
            default:
            begin
                cd_we = 1'b0;
            end
        endcase
        case (state_reg)
            S_IK:    cd_raddr = {i_reg, k_reg};
            S_KJ:    cd_raddr = {k_reg, j_reg};
            S_IJ:    cd_raddr = {i_reg, j_reg};
            S_INIR:  cd_raddr = {nlast, NB'(sj_reg)};
            S_RK:    cd_raddr = {NB'(sj_reg), NB'(sk_reg)};
            default: cd_raddr = '0;
        endcase
    end

    // Finish-time RAM ports.
    always_comb
    begin
        ef_we    = 1'b0;
        ef_waddr = {set_reg, sj_reg};
        ef_wdata = twt_pkg::INF;
        case (state_reg)
            S_EFCLR:
            begin
                ef_we = 1'b1;
            end
            S_INIW:
            begin
                ef_we    = 1'b1;
                ef_waddr = {{MS{1'b0}}, sj_reg};
                ef_wdata = cd_rdata;
            end
            S_RKU:
            begin
                ef_we    = alu_less;
                ef_waddr = {set_reg, sk_reg};
                ef_wdata = alu_sum;
            end
            S_VNU:
            begin
                ef_we    = alu_less;
                ef_waddr = {next_set, sj_reg};
                ef_wdata = alu_sum;
            end
            default:
            begin
                ef_we = 1'b0;
            end
        endcase
        case (state_reg)
            S_RKE:   ef_raddr = {set_reg, sk_reg};
            S_VN:    ef_raddr = {next_set, sj_reg};
            default: ef_raddr = {set_reg, sj_reg};
        endcase
    end

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_a = ik_reg;
        alu_b = kj_reg;
        alu_c = cd_rdata;
        case (state_reg)
            S_RKU:
            begin
                alu_a = efj_reg;
                alu_b = cdjk_reg;
                alu_c = ef_rdata;
            end
            S_VJW:
            begin
                alu_a = start_t;
                alu_b = service_ext;
                alu_c = '0;
            end
            S_VNU:
            begin
                alu_a = done_reg;
                alu_b = '0;
                alu_c = ef_rdata;
            end
            default:
            begin
                alu_a = ik_reg;
            end
        endcase
    end

    twt_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .c    (alu_c),
        .sum  (alu_sum),
        .less (alu_less)
    );

    twt_ram #(.WIDTH(DW), .DEPTH(1 << DAW)) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    twt_ram #(.WIDTH(DW), .DEPTH(1 << DAW)) u_closed_ram (
        .clk   (clk),
        .we    (cd_we),
        .waddr (cd_waddr),
        .wdata (cd_wdata),
        .raddr (cd_raddr),
        .rdata (cd_rdata)
    );

    twt_ram #(.WIDTH(DW), .DEPTH(1 << EAW)) u_finish_ram (
        .clk   (clk),
        .we    (ef_we),
        .waddr (ef_waddr),
        .wdata (ef_wdata),
        .raddr (ef_raddr),
        .rdata (ef_rdata)
    );

    // Store windows hold no reset value.
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == twt_pkg::OP_WINDOW) && (int'(store_index) < MAX_STORES))
        begin
            win_open_reg[SB'(store_index)]    <= open_time & TMASK;
            win_close_reg[SB'(store_index)]   <= close_time & TMASK;
            win_service_reg[SB'(store_index)] <= service_time & TMASK;
        end
    end

    // Sequencer, counters and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_DCLR;
            node_count_reg  <= NCW'(2);
            store_count_reg <= SCW'(1);
            clr_reg         <= '0;
            cp_reg          <= '0;
            cp_wv_reg       <= 1'b0;
            done_pulse_reg  <= 1'b0;
            i_reg           <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
            sj_reg          <= '0;
            sk_reg          <= '0;
            set_reg         <= '0;
            best_reg        <= '0;
        end
        else
        begin
            done_pulse_reg <= 1'b0;

            // Configuration transfers.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    twt_pkg::CFG_NODE_COUNT:
                    begin
                        if (cfg_data < 7'd2)
                        begin
                            node_count_reg <= NCW'(2);
                        end
                        else if (int'(cfg_data) > MAX_NODES)
                        begin
                            node_count_reg <= NCW'(MAX_NODES);
                        end
                        else
                        begin
                            node_count_reg <= NCW'(cfg_data);
                        end
                    end
                    twt_pkg::CFG_STORE_COUNT:
                    begin
                        if (cfg_data[4:0] == 5'd0)
                        begin
                            store_count_reg <= SCW'(1);
                        end
                        else if (int'(cfg_data[4:0]) > MAX_STORES)
                        begin
                            store_count_reg <= SCW'(MAX_STORES);
                        end
                        else
                        begin
                            store_count_reg <= SCW'(cfg_data[4:0]);
                        end
                    end
                    default:
                    begin
                        store_count_reg <= store_count_reg;
                    end
                endcase
            end

            case (state_reg)
                // Reset sweep of the road table.
                S_DCLR:
                begin
                    clr_reg <= clr_reg + DAW'(1);
                    if (clr_reg == {DAW{1'b1}})
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (opcode)
                            twt_pkg::OP_ROAD:
                            begin
                                if (road_ok)
                                begin
                                    road_a_reg   <= NB'(road_from);
                                    road_b_reg   <= NB'(road_to);
                                    road_len_reg <= DW'(road_length & TMASK);
                                    state_reg    <= S_ROAD2;
                                end
                            end
                            twt_pkg::OP_RUN:
                            begin
                                cp_reg    <= '0;
                                cp_wv_reg <= 1'b0;
                                state_reg <= S_COPY;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_ROAD2:
                begin
                    state_reg <= S_IDLE;
                end

                // Copy the road table into the working table.
                S_COPY:
                begin
                    cp_wa_reg <= cp_reg;
                    cp_wv_reg <= 1'b1;
                    cp_reg    <= cp_reg + DAW'(1);
                    if (cp_reg == {DAW{1'b1}})
                    begin
                        state_reg <= S_CPT;
                    end
                end

                S_CPT:
                begin
                    cp_wv_reg <= 1'b0;
                    i_reg     <= '0;
                    j_reg     <= '0;
                    k_reg     <= '0;
                    state_reg <= S_IK;
                end

                // Shortest-path closure, one relaxation per pass.
                S_IK:
                begin
                    state_reg <= S_IKW;
                end

                S_IKW:
                begin
                    ik_reg    <= cd_rdata;
                    state_reg <= S_KJ;
                end

                S_KJ:
                begin
                    state_reg <= S_IJ;
                end

                S_IJ:
                begin
                    kj_reg    <= cd_rdata;
                    state_reg <= S_FWU;
                end

                S_FWU:
                begin
                    if (j_reg == nlast)
                    begin
                        j_reg <= '0;
                        if (i_reg == nlast)
                        begin
                            i_reg <= '0;
                            if (k_reg == nlast)
                            begin
                                set_reg   <= '0;
                                sj_reg    <= '0;
                                state_reg <= S_EFCLR;
                            end
                            else
                            begin
                                k_reg     <= k_reg + NB'(1);
                                state_reg <= S_IK;
                            end
                        end
                        else
                        begin
                            i_reg     <= i_reg + NB'(1);
                            state_reg <= S_IK;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + NB'(1);
                        state_reg <= S_KJ;
                    end
                end

                // Clear the finish-time table over the sets in use.
                S_EFCLR:
                begin
                    if (sj_reg == mlast)
                    begin
                        sj_reg <= '0;
                        if (set_reg == full_mask)
                        begin
                            set_reg   <= '0;
                            state_reg <= S_INIR;
                        end
                        else
                        begin
                            set_reg <= set_reg + MS'(1);
                        end
                    end
                    else
                    begin
                        sj_reg <= sj_reg + SB'(1);
                    end
                end

                // Empty set: travel time from the start node to each store.
                S_INIR:
                begin
                    state_reg <= S_INIW;
                end

                S_INIW:
                begin
                    if (sj_reg == mlast)
                    begin
                        sj_reg    <= '0;
                        state_reg <= S_RJ;
                    end
                    else
                    begin
                        sj_reg    <= sj_reg + SB'(1);
                        state_reg <= S_INIR;
                    end
                end

                // Relax end stores within one set through the closed distances.
                S_RJ:
                begin
                    state_reg <= S_RJW;
                end

                S_RJW:
                begin
                    efj_reg   <= ef_rdata;
                    sk_reg    <= '0;
                    state_reg <= S_RK;
                end

                S_RK:
                begin
                    state_reg <= S_RKE;
                end

                S_RKE:
                begin
                    cdjk_reg  <= cd_rdata;
                    state_reg <= S_RKU;
                end

                S_RKU:
                begin
                    if (sk_reg == mlast)
                    begin
                        if (sj_reg == mlast)
                        begin
                            sj_reg    <= '0;
                            state_reg <= S_VJ;
                        end
                        else
                        begin
                            sj_reg    <= sj_reg + SB'(1);
                            state_reg <= S_RJ;
                        end
                    end
                    else
                    begin
                        sk_reg    <= sk_reg + SB'(1);
                        state_reg <= S_RK;
                    end
                end

                // Visit a store that is not yet in the set.
                S_VJ:
                begin
                    if (set_reg[sj_reg])
                    begin
                        state_reg <= S_VADV;
                    end
                    else
                    begin
                        state_reg <= S_VJW;
                    end
                end

                S_VJW:
                begin
                    if (ef_rdata <= close_ext)
                    begin
                        done_reg  <= alu_sum;
                        state_reg <= S_VN;
                    end
                    else
                    begin
                        state_reg <= S_VADV;
                    end
                end

                S_VN:
                begin
                    state_reg <= S_VNU;
                end

                S_VNU:
                begin
                    state_reg <= S_VADV;
                end

                S_VADV:
                begin
                    if (sj_reg == mlast)
                    begin
                        sj_reg <= '0;
                        if (set_reg == (full_mask - MS'(1)))
                        begin
                            set_reg   <= '0;
                            best_reg  <= '0;
                            state_reg <= S_SR;
                        end
                        else
                        begin
                            set_reg   <= set_reg + MS'(1);
                            state_reg <= S_RJ;
                        end
                    end
                    else
                    begin
                        sj_reg    <= sj_reg + SB'(1);
                        state_reg <= S_VJ;
                    end
                end

                // Scan for the largest set with a finite finish time.
                S_SR:
                begin
                    state_reg <= S_SC;
                end

                S_SC:
                begin
                    best_reg <= best_new;
                    if ((sj_reg == mlast) && (set_reg == full_mask))
                    begin
                        max_stores_reg <= best_new;
                        done_pulse_reg <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else if (sj_reg == mlast)
                    begin
                        sj_reg    <= '0;
                        set_reg   <= set_reg + MS'(1);
                        state_reg <= S_SR;
                    end
                    else
                    begin
                        sj_reg    <= sj_reg + SB'(1);
                        state_reg <= S_SR;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
